FILE: hw/rtl/circular_deque_defines.svh
// Assertion macros for the circular deque RTL.
// Clock clk and active-low reset arst_n must be in scope where they are used.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// same-cycle implication
`define CDQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CDQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/cdq_pkg.sv
// Shared constants, types and ring-pointer helpers for the circular deque.
// No dependencies.
package cdq_pkg;

	localparam int DEPTH  = 1024;
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CAP_W  = 11;
	localparam int DATA_W = 32;
	localparam int KIND_W = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	typedef enum logic [KIND_W-1:0] {
		KIND_INS_FRONT = 2'd0,
		KIND_INS_REAR  = 2'd1,
		KIND_REM_FRONT = 2'd2,
		KIND_REM_REAR  = 2'd3
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic take;   // capture the accepted item
		logic exec;   // apply the operation, issue RAM write or read
		logic fetch;  // load RAM read data into the end register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_rd;  // operation will need a RAM read for the new end
	} status_t;

	function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] i);
		return (i == PTR_W'(DEPTH - 1)) ? '0 : i + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] i);
		return (i == '0) ? PTR_W'(DEPTH - 1) : i - PTR_W'(1);
	endfunction

endpackage

FILE: hw/rtl/cdq_req_if.sv
// Request channel of the circular deque: operation kind and value.
// Depends on cdq_pkg.
interface cdq_req_if;
	logic                                valid;
	logic                                ready;
	logic [cdq_pkg::KIND_W-1:0]          kind;
	logic signed [cdq_pkg::DATA_W-1:0]   value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

FILE: hw/rtl/cdq_rsp_if.sv
// Result channel of the circular deque: status flags and end values.
// Depends on cdq_pkg.
interface cdq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                ok;
	logic                                empty_res;
	logic                                full_res;
	logic signed [cdq_pkg::DATA_W-1:0]   front_value;
	logic signed [cdq_pkg::DATA_W-1:0]   rear_value;

	modport source (output valid, output ok, output empty_res, output full_res,
		output front_value, output rear_value, input ready);
	modport sink   (input valid, input ok, input empty_res, input full_res,
		input front_value, input rear_value, output ready);
endinterface

FILE: hw/rtl/circular_deque.sv
// Circular deque top level: bounded double-ended queue over a ring RAM.
// Depends on cdq_pkg, cdq_req_if, cdq_rsp_if, cdq_ctrl, cdq_dp, defines header.
//
// Usage:
//   req carries one operation per item: kind (insert front, insert rear,
//   remove front, remove rear) and value (used by inserts only).
//   rsp returns one item per request: ok, empty/full flags after the
//   operation, and the front and rear entries (zero when empty).
//   cfg_we/cfg_wdata set the capacity; 0 acts as 1, above the RAM depth
//   acts as the depth. Write it only while no request is in flight.
// Timing:
//   req.ready is high only while idle. After acceptance the controller goes
//   through ST_EXEC to ST_RESP, where rsp.valid is high, for inserts, refused
//   ops and removals that empty the deque; other removals pass through ST_FETCH
//   between them for the registered RAM read that fetches the new front or
//   rear entry. A new request is taken only after the result has been taken.
// Reset: arst_n empties the deque and sets capacity to 1024; RAM contents
//   are not cleared (never-written slots are never read back).
// Stall: while rsp.ready is low the result holds and no new item is taken.
`include "circular_deque_defines.svh"

module circular_deque (
	input  logic                               clk,
	input  logic                               arst_n,
	cdq_req_if.sink                            req,
	cdq_rsp_if.source                          rsp,
	input  logic                               cfg_we,
	input  logic [cdq_pkg::CAP_W-1:0]          cfg_wdata
);
	cdq_pkg::cmd_t    cmd;
	cdq_pkg::status_t status;
	logic             req_ready, rsp_valid;

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	cdq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.status      (status),
		.kind        (req.kind),
		.value       (req.value),
		.ok          (rsp.ok),
		.empty_res   (rsp.empty_res),
		.full_res    (rsp.full_res),
		.front_value (rsp.front_value),
		.rear_value  (rsp.rear_value)
	);

	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;

	`CDQ_ASSERT_IMP(a_no_take_while_rsp, rsp_valid, !req_ready, "request taken during response")
	`CDQ_ASSERT_IMP(a_empty_zero, rsp_valid && rsp.empty_res,
		rsp.front_value == '0 && rsp.rear_value == '0, "nonzero end value when empty")
	`CDQ_ASSERT_IMP(a_full_not_empty, rsp.full_res, !rsp.empty_res, "full and empty together")
	`CDQ_ASSERT_NXT(a_exec_after_take, cmd.take, cmd.exec, "accepted item not executed")
endmodule

FILE: hw/rtl/cdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: hw/rtl/cdq_ctrl.sv
// Sequencing FSM for the circular deque: accept, execute, fetch, respond.
// Depends on cdq_pkg.
module cdq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  cdq_pkg::status_t status,
	output cdq_pkg::cmd_t    cmd
);
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FETCH,
		ST_RESP
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= status.need_rd ? ST_FETCH : ST_RESP;
				end
				ST_FETCH: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (rsp_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		req_ready = (state_q == ST_IDLE);
		rsp_valid = (state_q == ST_RESP);
		cmd.take  = req_ready && req_valid;
		cmd.exec  = (state_q == ST_EXEC);
		cmd.fetch = (state_q == ST_FETCH);
	end
endmodule

FILE: hw/rtl/cdq_dp.sv
// Datapath of the circular deque: ring RAM, pointers, fill count, end registers.
// Depends on cdq_pkg and cdq_ram.
module cdq_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cdq_pkg::CAP_W-1:0]           cfg_wdata,
	input  cdq_pkg::cmd_t                       cmd,
	output cdq_pkg::status_t                    status,
	input  logic [cdq_pkg::KIND_W-1:0]          kind,
	input  logic signed [cdq_pkg::DATA_W-1:0]   value,
	output logic                                ok,
	output logic                                empty_res,
	output logic                                full_res,
	output logic signed [cdq_pkg::DATA_W-1:0]   front_value,
	output logic signed [cdq_pkg::DATA_W-1:0]   rear_value
);
	logic [cdq_pkg::CAP_W-1:0]  cap_q;
	cdq_pkg::kind_t             kind_q;
	logic [cdq_pkg::DATA_W-1:0] value_q;
	logic [cdq_pkg::PTR_W-1:0]  head_q, tail_q;
	logic [cdq_pkg::CNT_W-1:0]  count_q;
	logic [cdq_pkg::DATA_W-1:0] front_q, rear_q;
	logic                       ok_q;

	logic [cdq_pkg::CNT_W-1:0]  eff_cap;
	logic                       ins_ok, rem_ok;
	logic [cdq_pkg::PTR_W-1:0]  head_dec, head_inc, tail_inc, tail_dec;
	logic                       ram_we;
	logic [cdq_pkg::PTR_W-1:0]  ram_waddr, ram_raddr;
	logic [cdq_pkg::DATA_W-1:0] ram_rdata;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = cdq_pkg::CNT_W'(1);
		end else if (32'(cap_q) > 32'(cdq_pkg::DEPTH)) begin
			eff_cap = cdq_pkg::CNT_W'(cdq_pkg::DEPTH);
		end else begin
			eff_cap = cdq_pkg::CNT_W'(cap_q);
		end
	end

	assign head_dec = cdq_pkg::ring_dec(head_q);
	assign head_inc = cdq_pkg::ring_inc(head_q);
	assign tail_inc = cdq_pkg::ring_inc(tail_q);
	assign tail_dec = cdq_pkg::ring_dec(tail_q);

	assign ins_ok = (count_q < eff_cap);
	assign rem_ok = (count_q != '0);

	// a removal leaving at least one entry must read the new end from the ring
	assign status.need_rd = kind_q[1] && (count_q > cdq_pkg::CNT_W'(1));

	assign ram_we    = cmd.exec && !kind_q[1] && ins_ok;
	assign ram_waddr = (kind_q == cdq_pkg::KIND_INS_FRONT) ? head_dec : tail_q;
	// new front slot, or the slot before the new tail
	assign ram_raddr = (kind_q == cdq_pkg::KIND_REM_FRONT) ? head_inc
		: cdq_pkg::ring_dec(tail_dec);

	cdq_ram #(
		.WIDTH (cdq_pkg::DATA_W),
		.DEPTH (cdq_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (value_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= cdq_pkg::CAP_RESET;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			ok_q    <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (cmd.exec) begin
				case (kind_q)
					cdq_pkg::KIND_INS_FRONT: begin
						ok_q <= ins_ok;
						if (ins_ok) begin
							head_q  <= head_dec;
							count_q <= count_q + cdq_pkg::CNT_W'(1);
						end
					end
					cdq_pkg::KIND_INS_REAR: begin
						ok_q <= ins_ok;
						if (ins_ok) begin
							tail_q  <= tail_inc;
							count_q <= count_q + cdq_pkg::CNT_W'(1);
						end
					end
					cdq_pkg::KIND_REM_FRONT: begin
						ok_q <= rem_ok;
						if (rem_ok) begin
							head_q  <= head_inc;
							count_q <= count_q - cdq_pkg::CNT_W'(1);
						end
					end
					default: begin
						ok_q <= rem_ok;
						if (rem_ok) begin
							tail_q  <= tail_dec;
							count_q <= count_q - cdq_pkg::CNT_W'(1);
						end
					end
				endcase
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q  <= cdq_pkg::kind_t'(kind);
			value_q <= value;
		end
		if (ram_we) begin
			if (kind_q == cdq_pkg::KIND_INS_FRONT) begin
				front_q <= value_q;
				if (!rem_ok) rear_q <= value_q;
			end else begin
				rear_q <= value_q;
				if (!rem_ok) front_q <= value_q;
			end
		end
		if (cmd.fetch) begin
			if (kind_q == cdq_pkg::KIND_REM_FRONT) front_q <= ram_rdata;
			else rear_q <= ram_rdata;
		end
	end

	assign ok          = ok_q;
	assign empty_res   = (count_q == '0);
	assign full_res    = (count_q >= eff_cap);
	assign front_value = empty_res ? '0 : front_q;
	assign rear_value  = empty_res ? '0 : rear_q;
endmodule

FILE: test/tb_circular_deque.sv
// Self-checking bench for circular_deque: a directed table, then random insert/remove traffic.
// Results are checked against an in-bench ring model or typed rows, under random stalls on both channels.
// Depends on cdq_pkg, cdq_req_if, cdq_rsp_if and the circular_deque RTL.
module tb_circular_deque;
	import cdq_pkg::*;

	localparam int unsigned STALL_LIMIT = 3000;

	typedef struct packed {
		logic        ok;
		logic        empty_res;
		logic        full_res;
		logic [31:0] front;
		logic [31:0] rear;
	} view_t;

	typedef struct packed {
		bit          is_cfg;
		logic [10:0] cap;
		kind_t       kind;
		logic [31:0] value;
		bit          typed;
		view_t       view;
	} step_t;

	localparam view_t NO_VIEW       = '0;
	localparam view_t REFUSED_EMPTY = '{1'b0, 1'b1, 1'b0, 32'h0, 32'h0};
	localparam view_t DRAINED       = '{1'b1, 1'b1, 1'b0, 32'h0, 32'h0};

	// directed steps; rows with typed=1 carry a hand-written result
	localparam step_t DIRECTED [24] = '{
		'{1'b0, 11'd0, KIND_REM_FRONT, 32'h0000_0000, 1'b1, REFUSED_EMPTY},
		'{1'b0, 11'd0, KIND_REM_REAR,  32'hFFFF_FFFF, 1'b1, REFUSED_EMPTY},
		'{1'b0, 11'd0, KIND_INS_REAR,  32'h7FFF_FFFF, 1'b1,
			'{1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF}},
		// head wraps below slot zero
		'{1'b0, 11'd0, KIND_INS_FRONT, 32'h8000_0000, 1'b1,
			'{1'b1, 1'b0, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF}},
		'{1'b0, 11'd0, KIND_INS_REAR,  32'hFFFF_FFFF, 1'b0, NO_VIEW},
		'{1'b0, 11'd0, KIND_INS_FRONT, 32'h0000_0000, 1'b0, NO_VIEW},
		'{1'b0, 11'd0, KIND_REM_REAR,  32'h1234_5678, 1'b0, NO_VIEW},
		'{1'b0, 11'd0, KIND_REM_FRONT, 32'h0000_0000, 1'b0, NO_VIEW},
		'{1'b0, 11'd0, KIND_REM_FRONT, 32'h0000_0000, 1'b0, NO_VIEW},
		// one entry left; capacity 1 makes it full
		'{1'b1, 11'd1, KIND_INS_FRONT, 32'h0, 1'b0, NO_VIEW},
		'{1'b0, 11'd0, KIND_INS_REAR,  32'h1234_5678, 1'b1,
			'{1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF}},
		'{1'b0, 11'd0, KIND_REM_REAR,  32'h0000_0000, 1'b1, DRAINED},
		'{1'b0, 11'd0, KIND_INS_FRONT, 32'hA5A5_A5A5, 1'b1,
			'{1'b1, 1'b0, 1'b1, 32'hA5A5_A5A5, 32'hA5A5_A5A5}},
		// capacity 0 behaves as 1
		'{1'b1, 11'd0, KIND_INS_FRONT, 32'h0, 1'b0, NO_VIEW},
		'{1'b0, 11'd0, KIND_INS_FRONT, 32'h5A5A_5A5A, 1'b1,
			'{1'b0, 1'b0, 1'b1, 32'hA5A5_A5A5, 32'hA5A5_A5A5}},
		'{1'b0, 11'd0, KIND_REM_FRONT, 32'h0000_0000, 1'b1, DRAINED},
		// oversize capacity clamps to the store depth
		'{1'b1, 11'd2047, KIND_INS_FRONT, 32'h0, 1'b0, NO_VIEW},
		'{1'b0, 11'd0, KIND_INS_REAR,  32'h0000_0001, 1'b0, NO_VIEW},
		'{1'b0, 11'd0, KIND_INS_FRONT, 32'hFFFF_FFFE, 1'b0, NO_VIEW},
		// shrink below the fill: entries kept, deque reads full
		'{1'b1, 11'd1, KIND_INS_FRONT, 32'h0, 1'b0, NO_VIEW},
		'{1'b0, 11'd0, KIND_INS_FRONT, 32'h0000_0007, 1'b1,
			'{1'b0, 1'b0, 1'b1, 32'hFFFF_FFFE, 32'h0000_0001}},
		'{1'b0, 11'd0, KIND_REM_FRONT, 32'h0000_0000, 1'b0, NO_VIEW},
		'{1'b0, 11'd0, KIND_REM_REAR,  32'h0000_0000, 1'b1, DRAINED},
		'{1'b1, 11'd1024, KIND_INS_FRONT, 32'h0, 1'b0, NO_VIEW}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we;
	logic [10:0] cfg_wdata;

	cdq_req_if req_ch ();
	cdq_rsp_if rsp_ch ();

	circular_deque dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// ring model
	logic [31:0] ring [DEPTH];
	int unsigned head_slot = 0;
	int unsigned tail_slot = 0;
	int unsigned fill = 0;
	int unsigned cap_reg = 1024;

	view_t       deque_views [$];
	bit          pinned_valid;
	view_t       pinned_view;
	bit          steady;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic view_t deque_apply(kind_t k, logic [31:0] v);
		view_t       r;
		int unsigned lim;
		lim = (cap_reg == 0) ? 1 : (cap_reg > DEPTH) ? DEPTH : cap_reg;
		r = '0;
		case (k)
			KIND_INS_FRONT, KIND_INS_REAR: begin
				if (fill < lim) begin
					if (k == KIND_INS_FRONT) begin
						head_slot = (head_slot + DEPTH - 1) % DEPTH;
						ring[head_slot] = v;
					end else begin
						ring[tail_slot] = v;
						tail_slot = (tail_slot + 1) % DEPTH;
					end
					fill++;
					r.ok = 1'b1;
				end
			end
			default: begin
				if (fill != 0) begin
					if (k == KIND_REM_FRONT)
						head_slot = (head_slot + 1) % DEPTH;
					else
						tail_slot = (tail_slot + DEPTH - 1) % DEPTH;
					fill--;
					r.ok = 1'b1;
				end
			end
		endcase
		r.empty_res = (fill == 0);
		r.full_res  = (fill >= lim);
		if (fill != 0) begin
			r.front = ring[head_slot];
			r.rear  = ring[(tail_slot + DEPTH - 1) % DEPTH];
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
		end
	endfunction

	// mostly short gaps, a few long ones, none in steady stretches
	function automatic int unsigned gap_len();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin : deque_watch
		view_t got;
		view_t want;
		bit    moved;
		moved = 1'b0;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				moved = 1'b1;
				got = '{rsp_ch.ok, rsp_ch.empty_res, rsp_ch.full_res,
					rsp_ch.front_value, rsp_ch.rear_value};
				if (deque_views.size() == 0) begin
					mismatches++;
					$display("%0t: result mismatch: expected no item, got %h", $time, got);
				end else begin
					want = deque_views.pop_front();
					check_field("ok", 32'(want.ok), 32'(got.ok));
					check_field("empty_res", 32'(want.empty_res), 32'(got.empty_res));
					check_field("full_res", 32'(want.full_res), 32'(got.full_res));
					check_field("front_value", want.front, got.front);
					check_field("rear_value", want.rear, got.rear);
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				moved = 1'b1;
				want = deque_apply(kind_t'(req_ch.kind), req_ch.value);
				deque_views.push_back(pinned_valid ? pinned_view : want);
			end
			if (moved) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
					$display("TEST FAILED");
					$finish;
				end
			end
		end
	end

	initial begin : result_pace
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			repeat (gap_len()) begin
				@(negedge clk);
				rsp_ch.ready <= 1'b0;
			end
			@(negedge clk);
			rsp_ch.ready <= 1'b1;
		end
	end

	task automatic send_op(kind_t k, logic [31:0] v, bit typed, view_t view);
		repeat (gap_len()) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.kind  <= k;
		req_ch.value <= v;
		pinned_valid <= typed;
		pinned_view  <= view;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	task automatic set_capacity(logic [10:0] c);
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (deque_views.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cap_reg = c;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned plan_cap [6];
		int unsigned plan_len [6];
		int unsigned plan_ins [6];
		kind_t       k;
		plan_cap = '{4, 1, 0, 0, 2047, 5};
		plan_len = '{200, 80, 40, 150, 1200, 150};
		plan_ins = '{50, 50, 50, 55, 97, 20};
		plan_cap[3] = $urandom_range(2, 40);
		req_ch.valid = 1'b0;
		req_ch.kind  = KIND_INS_FRONT;
		req_ch.value = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		pinned_valid = 1'b0;
		pinned_view  = NO_VIEW;
		steady       = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].is_cfg)
				set_capacity(DIRECTED[i].cap);
			else
				send_op(DIRECTED[i].kind, DIRECTED[i].value, DIRECTED[i].typed,
					DIRECTED[i].view);
		end

		// random phases; entries carry over between capacity changes
		for (int p = 0; p < 6; p++) begin
			set_capacity(11'(plan_cap[p]));
			for (int n = 0; n < plan_len[p]; n++) begin
				steady = (p == 1) || (p == 4 && n >= 600 && n < 800);
				if ($urandom_range(0, 99) < plan_ins[p])
					k = $urandom_range(0, 1) ? KIND_INS_REAR : KIND_INS_FRONT;
				else
					k = $urandom_range(0, 1) ? KIND_REM_REAR : KIND_REM_FRONT;
				send_op(k, $urandom, 1'b0, NO_VIEW);
			end
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (deque_views.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_req_if.sv
hw/rtl/cdq_rsp_if.sv
hw/rtl/cdq_ram.sv
hw/rtl/cdq_ctrl.sv
hw/rtl/cdq_dp.sv
hw/rtl/circular_deque.sv
test/tb_circular_deque.sv
